/* src/sv39_ptw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sv39_ptw_pkg: shared types and constants of the Sv39 table walker
// Field widths, request and register codes, controller states and the
// command/status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package sv39_ptw_pkg;

	localparam int TABLE_PAGES_DEF  = 64;
	localparam int PAGE_OFFSET_BITS = 12;
	localparam int VPN_W            = 9;
	localparam int PPN_W            = 44;
	localparam int VA_W             = 39;
	localparam int PA_W             = 56;
	localparam int PTE_W            = 64;
	localparam int FLAG_W           = 10;
	localparam int IDX_W            = 15;
	localparam int CFG_IDX_W        = 1;
	localparam int PTE_PPN_LSB      = 10;
	// virtual address bits kept after issue: level 1 and level 0 indices plus offset
	localparam int VA_KEEP_W        = PAGE_OFFSET_BITS + 2 * VPN_W;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_XLATE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_ROOT_PAGE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_PAGE = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK1,
		ST_WALK0,
		ST_DONE
	} ptw_state_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_FAULT,
		RES_LEAF
	} res_kind_t;

	typedef enum logic [1:0] {
		LVL_ROOT,
		LVL_MID,
		LVL_LAST
	} lvl_sel_t;

	typedef struct packed {
		logic              req_type;
		logic [IDX_W-1:0]  entry_index;
		logic [PTE_W-1:0]  entry_value;
		logic [VA_W-1:0]   virtual_addr;
	} in_item_t;

	typedef struct packed {
		logic              found;
		logic [PA_W-1:0]   phys_addr;
		logic [FLAG_W-1:0] leaf_flags;
		logic              range_fault;
	} out_item_t;

	typedef struct packed {
		logic      clear;
		logic      capture;
		logic      mem_wr;
		logic      rd_en;
		lvl_sel_t  lvl;
		logic      load_out;
		res_kind_t kind;
	} ctl_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic is_write;
		logic wr_ok;
		logic slot_ok;
		logic pte_valid;
		logic out_busy;
	} dp_sts_t;

endpackage

/* src/sv39_page_table_walk_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sv39_page_table_walk_top: Sv39 three-level page table walker
// Stores page table entries on write beats and translates 39-bit virtual
// addresses against them, one result beat per input beat.
//
//   channel | direction | handshake          | payload
//   in      | in        | in_valid/in_ready  | in_data   (in_item_t)
//   out     | out       | out_valid/out_ready| out_data  (out_item_t)
//   cfg     | in        | cfg_we             | cfg_index, cfg_data
//
// A translate beat passes ST_IDLE, ST_WALK1, ST_WALK0 and ST_DONE: acceptance
// issues the root read, ST_WALK1 and ST_WALK0 the middle and leaf reads of the
// single registered read port, and ST_DONE loads the result register, which
// offers the result beat; an invalid entry or range fault skips to ST_DONE.
// A write beat writes the store, or faults beyond it; ST_DONE loads its result.
// After reset a clearing pass zeroes all TABLE_PAGES*512 words of the store
// (32768 at the default); no beat is accepted meanwhile, cfg writes are.
// One beat is in work at a time; a stalled result holds the walk in its last
// state, and the next beat is taken while a finished result waits.
// ----------------------------------------------------------------------------
module sv39_page_table_walk_top #(
	parameter int TABLE_PAGES = sv39_ptw_pkg::TABLE_PAGES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  sv39_ptw_pkg::in_item_t             in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output sv39_ptw_pkg::out_item_t            out_data,
	input  logic                               cfg_we,
	input  logic [sv39_ptw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sv39_ptw_pkg::PPN_W-1:0]     cfg_data
);

	sv39_ptw_pkg::ctl_cmd_t cmd;
	sv39_ptw_pkg::dp_sts_t  sts;

	sv39_ptw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sv39_ptw_dp #(
		.TABLE_PAGES (TABLE_PAGES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

/* src/sv39_ptw_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sv39_ptw_dp: datapath of the Sv39 table walker
// Configuration registers, entry store with registered read, table slot
// check and address forming, captured address bits and the result register.
// ----------------------------------------------------------------------------
module sv39_ptw_dp #(
	parameter int TABLE_PAGES = sv39_ptw_pkg::TABLE_PAGES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sv39_ptw_pkg::in_item_t               in_data,
	output sv39_ptw_pkg::out_item_t              out_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic                                 cfg_we,
	input  logic [sv39_ptw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sv39_ptw_pkg::PPN_W-1:0]       cfg_data,
	input  sv39_ptw_pkg::ctl_cmd_t               cmd,
	output sv39_ptw_pkg::dp_sts_t                sts
);

	localparam int SLOT_W = $clog2(TABLE_PAGES);
	localparam int ADDR_W = SLOT_W + sv39_ptw_pkg::VPN_W;
	localparam int WORDS  = TABLE_PAGES * (2 ** sv39_ptw_pkg::VPN_W);
	localparam int VPN_W  = sv39_ptw_pkg::VPN_W;
	localparam int OFF_W  = sv39_ptw_pkg::PAGE_OFFSET_BITS;
	localparam int PPN_W  = sv39_ptw_pkg::PPN_W;

	logic [sv39_ptw_pkg::PTE_W-1:0]     mem [WORDS];
	logic [sv39_ptw_pkg::PTE_W-1:0]     rd_q;
	logic [PPN_W-1:0]                   root_q;
	logic [PPN_W-1:0]                   base_q;
	logic [sv39_ptw_pkg::VA_KEEP_W-1:0] va_q;
	logic [ADDR_W-1:0]                  clr_q;
	sv39_ptw_pkg::out_item_t            out_q;
	logic                               out_valid_q;

	logic [31:0]        widx_ext;
	logic [PPN_W-1:0]   page_sel;
	logic [VPN_W-1:0]   idx_sel;
	logic [PPN_W-1:0]   slot;
	logic               slot_ok;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ADDR_W-1:0]  wr_addr;
	logic [sv39_ptw_pkg::PTE_W-1:0] wr_data;
	logic               wr_en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
			base_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sv39_ptw_pkg::CFG_ROOT_PAGE: root_q <= cfg_data;
				sv39_ptw_pkg::CFG_BASE_PAGE: base_q <= cfg_data;
			endcase
		end
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + ADDR_W'(1);
		end
	end

	assign widx_ext = 32'(in_data.entry_index);

	// page and entry index of the level being looked up
	always_comb begin
		page_sel = root_q;
		idx_sel  = in_data.virtual_addr[OFF_W + 2 * VPN_W +: VPN_W];
		unique case (cmd.lvl)
			sv39_ptw_pkg::LVL_ROOT: begin
				page_sel = root_q;
				idx_sel  = in_data.virtual_addr[OFF_W + 2 * VPN_W +: VPN_W];
			end
			sv39_ptw_pkg::LVL_MID: begin
				page_sel = rd_q[sv39_ptw_pkg::PTE_PPN_LSB +: PPN_W];
				idx_sel  = va_q[OFF_W + VPN_W +: VPN_W];
			end
			sv39_ptw_pkg::LVL_LAST: begin
				page_sel = rd_q[sv39_ptw_pkg::PTE_PPN_LSB +: PPN_W];
				idx_sel  = va_q[OFF_W +: VPN_W];
			end
			default: begin
				page_sel = root_q;
				idx_sel  = in_data.virtual_addr[OFF_W + 2 * VPN_W +: VPN_W];
			end
		endcase
	end

	assign slot    = page_sel - base_q;
	assign slot_ok = (slot < PPN_W'(TABLE_PAGES));
	assign rd_addr = {slot[SLOT_W-1:0], idx_sel};

	assign wr_en   = cmd.clear || cmd.mem_wr;
	assign wr_addr = cmd.clear ? clr_q : widx_ext[ADDR_W-1:0];
	assign wr_data = cmd.clear ? '0 : in_data.entry_value;

	// entry store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			va_q <= in_data.virtual_addr[sv39_ptw_pkg::VA_KEEP_W-1:0];
		end
	end

	// result register; the walk only loads it when no beat waits or the waiting beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.found       <= (cmd.kind == sv39_ptw_pkg::RES_LEAF);
			out_q.range_fault <= (cmd.kind == sv39_ptw_pkg::RES_FAULT);
			if (cmd.kind == sv39_ptw_pkg::RES_LEAF) begin
				out_q.phys_addr  <= {rd_q[sv39_ptw_pkg::PTE_PPN_LSB +: PPN_W], va_q[OFF_W-1:0]};
				out_q.leaf_flags <= rd_q[sv39_ptw_pkg::FLAG_W-1:0];
			end else begin
				out_q.phys_addr  <= '0;
				out_q.leaf_flags <= '0;
			end
		end
	end

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

	assign sts.clear_done = (clr_q == ADDR_W'(WORDS - 1));
	assign sts.is_write   = (in_data.req_type == sv39_ptw_pkg::REQ_WRITE);
	assign sts.wr_ok      = (widx_ext < 32'(WORDS));
	assign sts.slot_ok    = slot_ok;
	assign sts.pte_valid  = rd_q[0];
	assign sts.out_busy   = out_valid_q && !out_ready;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register loaded over a waiting beat");

	a_one_port_use: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_wr |-> (!cmd.rd_en && !cmd.clear))
		else $error("store write collides with a read or the clearing pass");

	a_read_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> slot_ok)
		else $error("store read issued for a page outside the store");

	a_found_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.found) |-> !out_q.range_fault)
		else $error("result shows both a leaf and a range fault");
`endif

endmodule

/* src/sv39_ptw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sv39_ptw_ctrl: controller of the Sv39 table walker
// Sequences the clearing pass, entry writes and the three-level walk, and
// chooses the kind of result handed to the result register.
// ----------------------------------------------------------------------------
module sv39_ptw_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  sv39_ptw_pkg::dp_sts_t   sts,
	output sv39_ptw_pkg::ctl_cmd_t  cmd
);

	sv39_ptw_pkg::ptw_state_t state_q, state_d;
	sv39_ptw_pkg::res_kind_t  kind_q, kind_d;
	logic                     accept;

	assign accept = in_valid && (state_q == sv39_ptw_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sv39_ptw_pkg::ST_CLEAR;
			kind_q  <= sv39_ptw_pkg::RES_NONE;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		unique case (state_q)
			sv39_ptw_pkg::ST_CLEAR: begin
				if (sts.clear_done) state_d = sv39_ptw_pkg::ST_IDLE;
			end
			sv39_ptw_pkg::ST_IDLE: begin
				if (accept) begin
					if (sts.is_write) begin
						kind_d  = sts.wr_ok ? sv39_ptw_pkg::RES_NONE : sv39_ptw_pkg::RES_FAULT;
						state_d = sv39_ptw_pkg::ST_DONE;
					end else if (!sts.slot_ok) begin
						kind_d  = sv39_ptw_pkg::RES_FAULT;
						state_d = sv39_ptw_pkg::ST_DONE;
					end else begin
						state_d = sv39_ptw_pkg::ST_WALK1;
					end
				end
			end
			sv39_ptw_pkg::ST_WALK1: begin
				if (!sts.pte_valid) begin
					kind_d  = sv39_ptw_pkg::RES_NONE;
					state_d = sv39_ptw_pkg::ST_DONE;
				end else if (!sts.slot_ok) begin
					kind_d  = sv39_ptw_pkg::RES_FAULT;
					state_d = sv39_ptw_pkg::ST_DONE;
				end else begin
					state_d = sv39_ptw_pkg::ST_WALK0;
				end
			end
			sv39_ptw_pkg::ST_WALK0: begin
				state_d = sv39_ptw_pkg::ST_DONE;
				if (!sts.pte_valid) begin
					kind_d = sv39_ptw_pkg::RES_NONE;
				end else if (!sts.slot_ok) begin
					kind_d = sv39_ptw_pkg::RES_FAULT;
				end else begin
					kind_d = sv39_ptw_pkg::RES_LEAF;
				end
			end
			sv39_ptw_pkg::ST_DONE: begin
				if (!sts.out_busy) state_d = sv39_ptw_pkg::ST_IDLE;
			end
			default: begin
				state_d = sv39_ptw_pkg::ST_CLEAR;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready     = 1'b0;
		cmd.clear    = 1'b0;
		cmd.capture  = 1'b0;
		cmd.mem_wr   = 1'b0;
		cmd.rd_en    = 1'b0;
		cmd.lvl      = sv39_ptw_pkg::LVL_ROOT;
		cmd.load_out = 1'b0;
		cmd.kind     = kind_q;
		unique case (state_q)
			sv39_ptw_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
			end
			sv39_ptw_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = accept;
				cmd.mem_wr  = accept && sts.is_write && sts.wr_ok;
				cmd.rd_en   = accept && !sts.is_write && sts.slot_ok;
			end
			sv39_ptw_pkg::ST_WALK1: begin
				cmd.lvl   = sv39_ptw_pkg::LVL_MID;
				cmd.rd_en = sts.pte_valid && sts.slot_ok;
			end
			sv39_ptw_pkg::ST_WALK0: begin
				cmd.lvl   = sv39_ptw_pkg::LVL_LAST;
				cmd.rd_en = sts.pte_valid && sts.slot_ok;
			end
			sv39_ptw_pkg::ST_DONE: begin
				cmd.load_out = !sts.out_busy;
			end
			default: begin
				cmd.clear = 1'b0;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_read_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_en && (cmd.lvl != sv39_ptw_pkg::LVL_ROOT)) |-> $past(cmd.rd_en))
		else $error("lower-level read without the read of the level above");

	a_ready_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == sv39_ptw_pkg::ST_IDLE))
		else $error("input ready outside the idle state");

	a_load_in_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (state_q == sv39_ptw_pkg::ST_DONE))
		else $error("result loaded outside the done state");
`endif

endmodule
